/* rtl/core/pdr_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the planar
// dead-reckoning core. No dependencies.
package pdr_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int PHASE_W    = $clog2(4 * SINE_DEPTH);
  localparam int OFF_W      = $clog2(SINE_DEPTH);
  localparam int IDX_W      = OFF_W + 1;
  localparam int TRIG_W     = 17;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = 35;

  localparam logic [15:0] PERIOD_RESET = 16'd655;

  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598670;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  typedef struct packed {
    logic               clear;
    logic signed [15:0] accel_side;
    logic signed [15:0] accel_front;
    logic        [15:0] heading;
  } imu_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } nav_t;

  typedef logic [15:0] sine_tab_t [0:SINE_DEPTH];

  // Odd polynomial for sin(pi/2 * k/D) in Q30, rounded to Q1.15
  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x  = (64'(k) << 30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = C9;
      t  = C7 - ((t * x2) >> 30);
      t  = C5 - ((t * x2) >> 30);
      t  = C3 - ((t * x2) >> 30);
      t  = C1 - ((t * x2) >> 30);
      s  = (t * x) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32768) begin
        s = 64'd32768;
      end
      tab[k] = s[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end else if (v < -SUM_W'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/core/pdr_sincos.sv */
// Sine and cosine of a binary-angle heading from the quarter-wave table.
// Depends on pdr_pkg.
module pdr_sincos (
  input  logic        [15:0]                heading,
  output logic signed [pdr_pkg::TRIG_W-1:0] sin_val,
  output logic signed [pdr_pkg::TRIG_W-1:0] cos_val
);
  import pdr_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [1:0]         quad;
  logic [OFF_W-1:0]   off;

  function automatic logic signed [TRIG_W-1:0] lookup(input logic [1:0] q,
                                                      input logic [OFF_W-1:0] r);
    logic [IDX_W-1:0]         idx;
    logic signed [TRIG_W-1:0] mag;
    idx = q[0] ? (IDX_W'(SINE_DEPTH) - {1'b0, r}) : {1'b0, r};
    mag = $signed({1'b0, SINE_TABLE[idx]});
    return q[1] ? -mag : mag;
  endfunction

  assign phase   = heading[15 -: PHASE_W];
  assign quad    = phase[PHASE_W-1 -: 2];
  assign off     = phase[OFF_W-1:0];
  assign sin_val = lookup(quad, off);
  assign cos_val = lookup(quad + 2'd1, off);

endmodule

/* rtl/core/pdr_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on pdr_pkg.
module pdr_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [pdr_pkg::MUL_A_W-1:0]  a,
  input  logic signed [pdr_pkg::MUL_B_W-1:0]  b,
  output logic signed [pdr_pkg::PROD_W-1:0]   prod
);
  import pdr_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

/* rtl/core/planar_dead_reckoning.sv */
// Top level: planar dead reckoning, rotation plus two Euler integrations.
// Depends on pdr_pkg, pdr_sincos and pdr_mul.
//
//   channel  signals                              direction
//   imu      imu_valid, imu_stall, imu (imu_t)    in, one transfer per tick
//   nav      nav_valid, nav_stall, nav (nav_t)    out, one transfer per tick
//   period   period_valid, period_ready, period   in, sample period write
//
// A tick runs from its transfer to the result register as eight products
// through the one shared multiplier, then the commit. The next tick is
// taken the cycle after the commit. The commit waits while the result
// register is still full and stalled.
// Reset (rst, synchronous) zeroes the integrators and sets the period to 655.
module planar_dead_reckoning (
  input  logic            clk,
  input  logic            rst,
  input  logic            imu_valid,
  output logic            imu_stall,
  input  pdr_pkg::imu_t   imu,
  output logic            nav_valid,
  input  logic            nav_stall,
  output pdr_pkg::nav_t   nav,
  input  logic            period_valid,
  output logic            period_ready,
  input  logic [15:0]     period
);
  import pdr_pkg::*;

  localparam logic [3:0] ST_MUL_SC = 4'd0;
  localparam logic [3:0] ST_MUL_FS = 4'd1;
  localparam logic [3:0] ST_MUL_SS = 4'd2;
  localparam logic [3:0] ST_MUL_FC = 4'd3;
  localparam logic [3:0] ST_MUL_AX = 4'd4;
  localparam logic [3:0] ST_MUL_AY = 4'd5;
  localparam logic [3:0] ST_MUL_VX = 4'd6;
  localparam logic [3:0] ST_MUL_VY = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam logic signed [PROD_W-1:0] HALF23 = PROD_W'(1) << 22;
  localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) << 15;

  logic                        busy;
  logic [3:0]                  step;
  logic [15:0]                 sample_period;
  logic signed [15:0]          side;
  logic signed [15:0]          front;
  logic signed [TRIG_W-1:0]    sn;
  logic signed [TRIG_W-1:0]    cs;
  logic signed [TRIG_W-1:0]    sin_val;
  logic signed [TRIG_W-1:0]    cos_val;
  logic signed [MUL_A_W-1:0]   acc;
  logic signed [MUL_A_W-1:0]   ax;
  logic signed [MUL_A_W-1:0]   ay;
  logic signed [31:0]          velocity_x;
  logic signed [31:0]          velocity_y;
  logic signed [31:0]          position_x;
  logic signed [31:0]          position_y;
  logic signed [31:0]          position_y_next;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic                        mul_en;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    rnd23;
  logic signed [PROD_W-1:0]    rnd16;
  logic                        accept;
  logic                        out_free;
  logic                        commit;

  assign accept       = imu_valid && !imu_stall;
  assign imu_stall    = busy;
  assign period_ready = !busy;
  assign out_free     = !nav_valid || !nav_stall;
  assign commit       = busy && (step == ST_DONE) && out_free;

  pdr_sincos u_sincos (
    .heading (imu.heading),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  pdr_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    mul_en = busy && (step <= ST_MUL_VY);
    mul_a  = MUL_A_W'(side);
    mul_b  = cs;
    case (step)
      ST_MUL_SC: begin
        mul_a = MUL_A_W'(side);
        mul_b = cs;
      end
      ST_MUL_FS: begin
        mul_a = MUL_A_W'(front);
        mul_b = sn;
      end
      ST_MUL_SS: begin
        mul_a = MUL_A_W'(side);
        mul_b = sn;
      end
      ST_MUL_FC: begin
        mul_a = MUL_A_W'(front);
        mul_b = cs;
      end
      ST_MUL_AX: begin
        mul_a = ax;
        mul_b = $signed({1'b0, sample_period});
      end
      ST_MUL_AY: begin
        mul_a = ay;
        mul_b = $signed({1'b0, sample_period});
      end
      ST_MUL_VX: begin
        mul_a = MUL_A_W'(velocity_x);
        mul_b = $signed({1'b0, sample_period});
      end
      ST_MUL_VY: begin
        mul_a = MUL_A_W'(velocity_y);
        mul_b = $signed({1'b0, sample_period});
      end
      default: begin
        mul_a = MUL_A_W'(side);
        mul_b = cs;
      end
    endcase
  end

  // round half up, then back to Q16.16
  assign rnd23 = (prod + HALF23) >>> 23;
  assign rnd16 = (prod + HALF16) >>> 16;
  assign position_y_next = sat32(SUM_W'(position_y) + SUM_W'(rnd16));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      step          <= ST_MUL_SC;
      nav_valid     <= 1'b0;
      sample_period <= PERIOD_RESET;
      velocity_x    <= '0;
      velocity_y    <= '0;
      position_x    <= '0;
      position_y    <= '0;
    end else begin
      if (period_valid && period_ready) begin
        sample_period <= period;
      end
      if (commit) begin
        nav_valid <= 1'b1;
      end else if (nav_valid && !nav_stall) begin
        nav_valid <= 1'b0;
      end
      if (accept) begin
        busy  <= 1'b1;
        step  <= ST_MUL_SC;
        side  <= imu.accel_side;
        front <= imu.accel_front;
        sn    <= sin_val;
        cs    <= cos_val;
        if (imu.clear) begin
          velocity_x <= '0;
          velocity_y <= '0;
          position_x <= '0;
          position_y <= '0;
        end
      end else if (busy) begin
        if (step != ST_DONE) begin
          step <= step + 4'd1;
        end
        case (step)
          ST_MUL_FS: acc <= prod[MUL_A_W-1:0];
          ST_MUL_SS: ax  <= acc - prod[MUL_A_W-1:0];
          ST_MUL_FC: acc <= prod[MUL_A_W-1:0];
          ST_MUL_AX: ay  <= acc + prod[MUL_A_W-1:0];
          ST_MUL_AY: velocity_x <= sat32(SUM_W'(velocity_x) + SUM_W'(rnd23));
          ST_MUL_VX: velocity_y <= sat32(SUM_W'(velocity_y) + SUM_W'(rnd23));
          ST_MUL_VY: position_x <= sat32(SUM_W'(position_x) + SUM_W'(rnd16));
          ST_DONE: begin
            if (out_free) begin
              position_y <= position_y_next;
              busy       <= 1'b0;
              step       <= ST_MUL_SC;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && step == ST_DONE && out_free) begin
      nav.vel_x <= velocity_x;
      nav.vel_y <= velocity_y;
      nav.pos_x <= position_x;
      nav.pos_y <= position_y_next;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && step == ST_MUL_SC)
    else $error("tick transfer did not start the sequencer");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    busy && step != ST_DONE |=> busy && step == $past(step) + 4'd1)
    else $error("sequencer skipped or stalled a step");

  a_commit: assert property (@(posedge clk) disable iff (rst)
    busy && step == ST_DONE && out_free |=> nav_valid && !busy)
    else $error("result not committed on a free output register");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(nav_valid) |-> $past(busy) && $past(step) == ST_DONE)
    else $error("result raised outside the commit step");

endmodule
